// ===== sv/irpwd_pkg.sv =====
`timescale 1ns / 1ps

package irpwd_pkg;

  localparam int unsigned SENDER_ID_W   = 16;
  localparam int unsigned WEAPON_CODE_W = 8;
  localparam int unsigned PULSE_TICKS_W = 15;
  localparam int unsigned FRAME_WORD_W  = 32;
  localparam int unsigned CMP_W         = 16;

  localparam logic [CMP_W-1:0] HDR_LOW_MIN   = 16'd800;
  localparam logic [CMP_W-1:0] HDR_LOW_MAX   = 16'd1000;
  localparam logic [CMP_W-1:0] HDR_HIGH_MIN  = 16'd300;
  localparam logic [CMP_W-1:0] HDR_HIGH_MAX  = 16'd500;
  localparam logic [CMP_W-1:0] END_LOW_MIN   = 16'd450;
  localparam logic [CMP_W-1:0] END_LOW_MAX   = 16'd750;
  localparam logic [CMP_W-1:0] BIT_LOW_MIN   = 16'd45;
  localparam logic [CMP_W-1:0] BIT_LOW_MAX   = 16'd75;
  localparam logic [CMP_W-1:0] ZERO_HIGH_MIN = 16'd45;
  localparam logic [CMP_W-1:0] ZERO_HIGH_MAX = 16'd75;
  localparam logic [CMP_W-1:0] ONE_HIGH_MIN  = 16'd130;
  localparam logic [CMP_W-1:0] ONE_HIGH_MAX  = 16'd210;
  localparam logic [CMP_W-1:0] HIGH_LIMIT    = 16'd2500;
  localparam logic [CMP_W-1:0] LOW_GAP_LIMIT = 16'd2000;

  typedef struct packed {
    logic [SENDER_ID_W-1:0]   sender_id;
    logic [WEAPON_CODE_W-1:0] weapon_code;
  } frame_t;

endpackage

// ===== sv/irpwd_pulse_if.sv =====
`timescale 1ns / 1ps

interface irpwd_pulse_if
  import irpwd_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     pulse_level;
  logic [PULSE_TICKS_W-1:0] pulse_ticks;

  modport source (output valid, output pulse_level, output pulse_ticks, input ready);
  modport sink   (input valid, input pulse_level, input pulse_ticks, output ready);
endinterface

// ===== sv/irpwd_frame_if.sv =====
`timescale 1ns / 1ps

interface irpwd_frame_if
  import irpwd_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [SENDER_ID_W-1:0]   sender_id;
  logic [WEAPON_CODE_W-1:0] weapon_code;

  modport source (output valid, output sender_id, output weapon_code, input ready);
  modport sink   (input valid, input sender_id, input weapon_code, output ready);
endinterface

// ===== sv/ir_pulse_width_frame_decoder_core.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Carries                          Handshake
// pulse_i   in   pulse_level, pulse_ticks         valid/ready
// frame_o   out  sender_id, weapon_code           valid/ready
//
// One pulse word is taken per cycle; its frame word, if any, appears on frame_o
// in the following cycle, or waits in the second buffer entry behind a held word.
// The decode state is updated in the cycle of acceptance.
// A two-entry output buffer means pulse_i stalls only when two frame words wait.
// Reset clears the decode state and empties the output buffer.

module ir_pulse_width_frame_decoder_core
  import irpwd_pkg::*;
#(
  parameter int unsigned WIDTH_BITS = 15
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  irpwd_pulse_if.sink   pulse_i,
  irpwd_frame_if.source frame_o
);

  logic [FRAME_WORD_W-1:0] frame_word_q, frame_word_d;
  logic                    in_frame_q, in_frame_d;
  logic [WIDTH_BITS-1:0]   last_high_q, last_high_d;
  logic [WIDTH_BITS-1:0]   last_low_q, last_low_d;

  logic   out_valid_q, skid_valid_q;
  frame_t out_q, skid_q;

  logic                    accept;
  logic                    out_fire;
  logic                    emit;
  logic [CMP_W:0]          ticks_ext;
  logic [WIDTH_BITS-1:0]   ticks;
  logic [CMP_W-1:0]        hi_v, lo_v;
  logic                    is_header, is_end, is_zero, is_one;
  logic [FRAME_WORD_W-1:0] word_c;
  frame_t                  new_frame;

  assign pulse_i.ready = !skid_valid_q;
  assign accept        = pulse_i.valid && pulse_i.ready;
  assign out_fire      = out_valid_q && frame_o.ready;

  assign ticks_ext = (CMP_W + 1)'(pulse_i.pulse_ticks);
  assign ticks     = ticks_ext[WIDTH_BITS-1:0];
  assign hi_v      = CMP_W'(last_high_q);
  assign lo_v      = CMP_W'(last_low_q);

  assign is_header = (lo_v > HDR_LOW_MIN) && (lo_v < HDR_LOW_MAX)
                     && (hi_v > HDR_HIGH_MIN) && (hi_v < HDR_HIGH_MAX);
  assign is_end    = (lo_v > END_LOW_MIN) && (lo_v < END_LOW_MAX);
  assign is_zero   = in_frame_q && (lo_v > BIT_LOW_MIN) && (lo_v < BIT_LOW_MAX)
                     && (hi_v > ZERO_HIGH_MIN) && (hi_v < ZERO_HIGH_MAX);
  assign is_one    = in_frame_q && (lo_v > BIT_LOW_MIN) && (lo_v < BIT_LOW_MAX)
                     && (hi_v > ONE_HIGH_MIN) && (hi_v < ONE_HIGH_MAX);

  always_comb begin
    word_c      = frame_word_q;
    in_frame_d  = in_frame_q;
    last_high_d = last_high_q;
    last_low_d  = last_low_q;
    if (pulse_i.pulse_level) begin
      last_high_d = ticks;
      if (lo_v > LOW_GAP_LIMIT) begin
        in_frame_d = 1'b0;
      end
    end else begin
      if (hi_v != '0) begin
        priority if (is_header) begin
          in_frame_d = 1'b1;
        end else if (is_end) begin
          if (in_frame_q) begin
            in_frame_d = 1'b0;
            word_c[FRAME_WORD_W-1] = 1'b1;
          end else begin
            word_c = '0;
          end
        end else if (is_zero) begin
          word_c = {frame_word_q[FRAME_WORD_W-2:0], 1'b0};
        end else if (is_one) begin
          word_c = {frame_word_q[FRAME_WORD_W-2:0], 1'b1};
        end
      end
      if (hi_v > HIGH_LIMIT) begin
        last_high_d = '0;
      end
      last_low_d = ticks;
    end
    emit                  = word_c[FRAME_WORD_W-1];
    frame_word_d          = emit ? '0 : word_c;
    new_frame.sender_id   = word_c[SENDER_ID_W-1:0];
    new_frame.weapon_code = word_c[SENDER_ID_W+WEAPON_CODE_W-1:SENDER_ID_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_word_q <= '0;
      in_frame_q   <= 1'b0;
      last_high_q  <= '0;
      last_low_q   <= '0;
    end else if (accept) begin
      frame_word_q <= frame_word_d;
      in_frame_q   <= in_frame_d;
      last_high_q  <= last_high_d;
      last_low_q   <= last_low_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_fire) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept && emit;
      end
    end else if (accept && emit) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_fire) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept && emit) begin
        out_q <= new_frame;
      end
    end else if (accept && emit) begin
      skid_q <= new_frame;
    end
  end

  assign frame_o.valid       = out_valid_q;
  assign frame_o.sender_id   = out_q.sender_id;
  assign frame_o.weapon_code = out_q.weapon_code;

endmodule
